// ----- src/csvbt_pkg.sv -----
// csvbt_pkg: shared constants and types for the csv byte tokenizer
// character codes, quote modes, tokenizer state and result word layout
// no dependencies
`timescale 1ns / 1ps

package csvbt_pkg;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  localparam logic [1:0] ModeOut   = 2'd0;
  localparam logic [1:0] ModeIn    = 2'd1;
  localparam logic [1:0] ModeQseen = 2'd2;

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       cr_pending;
    logic       row_open;
  } tok_state_t;

  typedef struct packed {
    logic       row_end;
    logic       field_end;
    logic [7:0] char_out;
    logic       char_valid;
  } tok_result_t;

endpackage

// ----- src/csv_byte_tokenizer_unit.sv -----
// csv_byte_tokenizer_unit: top level of the csv byte tokenizer
// input register, tokenizer state, step logic and result register;
// uses csvbt_pkg, csvbt_step, csvbt_out_stage
//
// Splits a CSV byte stream into field content bytes and field and row
// boundaries. One word per cycle is taken at full rate while the result
// register can take the held word; a word that gives a result passes from the
// input register through the combinational step logic into the result
// register, which shows it on the master side. The step logic also updates the
// quote, cr and row state. Words that give no result (quotes, an lf after cr,
// end of stream with no row open) are dropped inside without a bubble.
`timescale 1ns / 1ps

module csv_byte_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] stream_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] char_out
  output logic [1:0] m_axis_tuser,   // [0] char_valid, [1] field_end
  output logic       m_axis_tlast    // row_end
);
  import csvbt_pkg::*;

  logic        in_valid_q;
  logic        in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_end_q;
  tok_state_t  state_q;
  tok_state_t  state_d;
  logic        emit;
  tok_result_t step_result;
  tok_result_t out_result;
  logic        out_ready;
  logic        advance;
  logic        in_accept;

  // the held word moves on when the result register can take it
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser;
    end
  end

  csvbt_step u_step (
    .state_i      (state_q),
    .data_byte_i  (in_byte_q),
    .stream_end_i (in_end_q),
    .state_o      (state_d),
    .emit_o       (emit),
    .result_o     (step_result)
  );

  csvbt_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (step_result),
    .take_i   (m_axis_tready),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result)
  );

  assign m_axis_tdata = out_result.char_out;
  assign m_axis_tuser = {out_result.field_end, out_result.char_valid};
  assign m_axis_tlast = out_result.row_end;

  // a row end always closes a field as well
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("row end without field end");

  // a content byte never carries a boundary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("content byte flagged as field end");

  // end of stream returns the tokenizer to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_end_q |=> state_q == '0)
    else $error("state not cleared after end of stream");

  // a pending cr means the row was just closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cr_pending |-> !state_q.row_open)
    else $error("cr pending with row open");

  // with an empty result register the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

// ----- src/csvbt_step.sv -----
// csvbt_step: next-state and result logic for one input word of the tokenizer
// purely combinational; uses csvbt_pkg
`timescale 1ns / 1ps

module csvbt_step (
  input  csvbt_pkg::tok_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   stream_end_i,
  output csvbt_pkg::tok_state_t  state_o,
  output logic                   emit_o,
  output csvbt_pkg::tok_result_t result_o
);
  import csvbt_pkg::*;

  logic is_quote;
  logic is_comma;
  logic is_lf;
  logic is_cr;

  assign is_quote = (data_byte_i == ChQuote);
  assign is_comma = (data_byte_i == ChComma);
  assign is_lf    = (data_byte_i == ChLf);
  assign is_cr    = (data_byte_i == ChCr);

  always_comb begin
    state_o            = state_i;
    state_o.cr_pending = 1'b0;
    emit_o             = 1'b0;
    result_o           = '0;

    if (stream_end_i) begin
      // close an open row, then back to reset state
      state_o            = '0;
      emit_o             = state_i.row_open;
      result_o.field_end = 1'b1;
      result_o.row_end   = 1'b1;
    end else if (state_i.cr_pending && is_lf) begin
      // lf right after a row-ending cr is swallowed
      emit_o = 1'b0;
    end else if (state_i.quote_mode == ModeIn) begin
      state_o.row_open = 1'b1;
      if (is_quote) begin
        state_o.quote_mode = ModeQseen;
      end else begin
        emit_o              = 1'b1;
        result_o.char_valid = 1'b1;
        result_o.char_out   = data_byte_i;
      end
    end else if (state_i.quote_mode == ModeQseen && is_quote) begin
      // doubled quote gives one literal quote
      state_o.quote_mode  = ModeIn;
      state_o.row_open    = 1'b1;
      emit_o              = 1'b1;
      result_o.char_valid = 1'b1;
      result_o.char_out   = ChQuote;
    end else begin
      // outside quotes, also the byte that follows a closing quote
      state_o.quote_mode = ModeOut;
      if (is_quote) begin
        state_o.quote_mode = ModeIn;
        state_o.row_open   = 1'b1;
      end else if (is_comma) begin
        state_o.row_open   = 1'b1;
        emit_o             = 1'b1;
        result_o.field_end = 1'b1;
      end else if (is_lf || is_cr) begin
        state_o.row_open   = 1'b0;
        state_o.cr_pending = is_cr;
        emit_o             = 1'b1;
        result_o.field_end = 1'b1;
        result_o.row_end   = 1'b1;
      end else begin
        state_o.row_open    = 1'b1;
        emit_o              = 1'b1;
        result_o.char_valid = 1'b1;
        result_o.char_out   = data_byte_i;
      end
    end
  end

endmodule

// ----- src/csvbt_out_stage.sv -----
// csvbt_out_stage: result register in front of the master-side stream port
// holds one result word until it is taken; uses csvbt_pkg
`timescale 1ns / 1ps

module csvbt_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  csvbt_pkg::tok_result_t result_i,
  input  logic                   take_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output csvbt_pkg::tok_result_t result_o
);
  import csvbt_pkg::*;

  logic        valid_q;
  logic        valid_d;
  tok_result_t result_q;

  // free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
